// ===== hdl/tmlq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmlq_pkg
// Shared constants, types and helpers of the tile mean level quantizer.
// ----------------------------------------------------------------------------
package tmlq_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_TILES_ACROSS = 2048;
    localparam int DEF_MAX_TILE_HEIGHT  = 64;
    localparam int DEF_MAX_TILE_WIDTH   = 32;

    // payload widths
    localparam int PIX_W     = 8;
    localparam int ROW_OUT_W = 12;
    localparam int COL_OUT_W = 11;
    localparam int LEVEL_W   = 5;

    // image geometry
    localparam int POS_W   = 12;
    localparam int IMG_W   = 13;
    localparam int IMG_MAX = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int TH_REG_W   = 7;
    localparam int TW_REG_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic [TH_REG_W-1:0] RST_TILE_HEIGHT  = 7'd5;
    localparam logic [TW_REG_W-1:0] RST_TILE_WIDTH   = 6'd2;
    localparam logic [IMG_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [IMG_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd20;

    // status of the level search unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_srch_stat;

    // smallest mean that reaches a level: ceil(lvl * 51 / 4)
    function automatic logic [PIX_W-1:0] level_threshold(input logic [LEVEL_W-1:0] lvl);
        logic [10:0] prod;
        prod = 11'(lvl) * 11'd51 + 11'd3;
        return prod[9:2];
    endfunction

endpackage

// ===== hdl/tmlq_pix_if.sv =====
// ----------------------------------------------------------------------------
// tmlq_pix_if
// Pixel stream channel: valid/ready handshake with gray level and frame mark.
// ----------------------------------------------------------------------------
interface tmlq_pix_if;
    logic                       valid;
    logic                       ready;
    logic [tmlq_pkg::PIX_W-1:0] pixel;
    logic                       frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// ===== hdl/tmlq_tile_if.sv =====
// ----------------------------------------------------------------------------
// tmlq_tile_if
// Tile result channel: valid/ready handshake with tile position and level.
// ----------------------------------------------------------------------------
interface tmlq_tile_if;
    logic                           valid;
    logic                           ready;
    logic [tmlq_pkg::ROW_OUT_W-1:0] tile_row;
    logic [tmlq_pkg::COL_OUT_W-1:0] tile_col;
    logic [tmlq_pkg::LEVEL_W-1:0]   level;
    logic                           frame_last;

    modport source (output valid, tile_row, tile_col, level, frame_last, input ready);
    modport sink   (input valid, tile_row, tile_col, level, frame_last, output ready);
endinterface

// ===== hdl/tmlq_level_search.sv =====
// ----------------------------------------------------------------------------
// tmlq_level_search
// Finds the density level of a tile sum by a bitwise search over the level
// thresholds, one level bit per cycle, with one multiply and compare a step.
// ----------------------------------------------------------------------------
module tmlq_level_search #(
    parameter int SUM_W  = 19,
    parameter int AREA_W = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_W-1:0]      i_sum,
    input  logic [AREA_W-1:0]     i_area,
    input  logic                  i_take,
    output tmlq_pkg::t_srch_stat  o_stat
);

    localparam int PROD_W = AREA_W + tmlq_pkg::PIX_W;
    localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam logic [2:0] TOP_BIT = 3'(tmlq_pkg::LEVEL_W - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [2:0]                   r_bit;
    logic [tmlq_pkg::LEVEL_W-1:0] r_lvl;
    logic [SUM_W-1:0]             r_sum;
    logic [AREA_W-1:0]            r_area;

    logic [tmlq_pkg::LEVEL_W-1:0] try_lvl;
    logic [PROD_W-1:0]            prod;
    logic                         hit;

    always_comb begin
        try_lvl = r_lvl | (tmlq_pkg::LEVEL_W'(1) << r_bit);
        prod    = PROD_W'(r_area) * PROD_W'(tmlq_pkg::level_threshold(try_lvl));
        hit     = (try_lvl <= tmlq_pkg::LEVEL_MAX) && (CMP_W'(r_sum) >= CMP_W'(prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && !r_done) begin
            if (r_bit == 3'd0) begin
                r_done <= 1'b1;
            end
        end else if (r_done && i_take) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    // payload: operands and the level under construction
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum  <= i_sum;
            r_area <= i_area;
            r_lvl  <= '0;
            r_bit  <= TOP_BIT;
        end else if (r_busy && !r_done) begin
            if (hit) begin
                r_lvl <= try_lvl;
            end
            if (r_bit != 3'd0) begin
                r_bit <= r_bit - 3'd1;
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_stat.level = r_lvl;

endmodule

// ===== hdl/tile_mean_level_quantizer.sv =====
// ----------------------------------------------------------------------------
// tile_mean_level_quantizer
// Sums gray pixels per tile column in a band store and emits a density level
// for each full tile when its bottom-right pixel arrives.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; a pixel that completes a tile holds the
//   input through the store update, 5 level search steps, one per bit, and
//   the move into the result register, longer while a waiting result stalls.
// Result path: a tile result passes the store update, the level search and
//   the result register, and is held back while the result channel stalls.
// Reset: synchronous; a clearing pass writes zero to each of the
//   MAX_TILES_ACROSS store entries, one a cycle, with the input held off.
// ----------------------------------------------------------------------------
module tile_mean_level_quantizer #(
    parameter int MAX_TILES_ACROSS = tmlq_pkg::DEF_MAX_TILES_ACROSS,
    parameter int MAX_TILE_HEIGHT  = tmlq_pkg::DEF_MAX_TILE_HEIGHT,
    parameter int MAX_TILE_WIDTH   = tmlq_pkg::DEF_MAX_TILE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tmlq_pix_if.sink                        i_pix,
    tmlq_tile_if.source                     o_tile,
    input  logic                            i_cfg_we,
    input  logic [tmlq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tmlq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int AW     = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
    localparam int CIT_W  = (MAX_TILE_WIDTH > 1) ? $clog2(MAX_TILE_WIDTH) : 1;
    localparam int RIT_W  = (MAX_TILE_HEIGHT > 1) ? $clog2(MAX_TILE_HEIGHT) : 1;
    localparam int TWC_W  = CIT_W + 1;
    localparam int THC_W  = RIT_W + 1;
    localparam int TWK_W  = (tmlq_pkg::TW_REG_W > TWC_W) ? tmlq_pkg::TW_REG_W : TWC_W;
    localparam int THK_W  = (tmlq_pkg::TH_REG_W > THC_W) ? tmlq_pkg::TH_REG_W : THC_W;
    localparam int SUM_W  = tmlq_pkg::PIX_W + $clog2(MAX_TILE_HEIGHT * MAX_TILE_WIDTH);
    localparam int AREA_W = THC_W + TWC_W;
    localparam int PC_W   = tmlq_pkg::IMG_W + TWC_W + 1;
    localparam int PR_W   = tmlq_pkg::IMG_W + THC_W + 1;
    localparam int TIC_K  = tmlq_pkg::POS_W + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_TILES_ACROSS - 1);

    localparam int POS_W = tmlq_pkg::POS_W;
    localparam int IMG_W = tmlq_pkg::IMG_W;

    typedef struct packed {
        logic                           wr;
        logic                           ovw;
        logic                           emit;
        logic                           last;
        logic                           fwd;
        logic [AW-1:0]                  addr;
        logic [tmlq_pkg::PIX_W-1:0]     pix;
        logic [tmlq_pkg::ROW_OUT_W-1:0] tile_row;
        logic [tmlq_pkg::COL_OUT_W-1:0] tile_col;
    } t_s1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tmlq_pkg::TH_REG_W-1:0] r_cfg_th;
    logic [tmlq_pkg::TW_REG_W-1:0] r_cfg_tw;
    logic [IMG_W-1:0]              r_cfg_iw;
    logic [IMG_W-1:0]              r_cfg_ih;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_th <= tmlq_pkg::RST_TILE_HEIGHT;
            r_cfg_tw <= tmlq_pkg::RST_TILE_WIDTH;
            r_cfg_iw <= tmlq_pkg::RST_IMAGE_WIDTH;
            r_cfg_ih <= tmlq_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tmlq_pkg::CFG_TILE_HEIGHT:  r_cfg_th <= i_cfg_data[tmlq_pkg::TH_REG_W-1:0];
                tmlq_pkg::CFG_TILE_WIDTH:   r_cfg_tw <= i_cfg_data[tmlq_pkg::TW_REG_W-1:0];
                tmlq_pkg::CFG_IMAGE_WIDTH:  r_cfg_iw <= i_cfg_data;
                tmlq_pkg::CFG_IMAGE_HEIGHT: r_cfg_ih <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes: zero acts as one, oversized acts as the maximum
    logic [TWK_W-1:0] tw_ext;
    logic [THK_W-1:0] th_ext;
    logic [TWC_W-1:0] tw;
    logic [THC_W-1:0] th;
    logic [IMG_W-1:0] iw;
    logic [IMG_W-1:0] ih;

    always_comb begin
        tw_ext = TWK_W'(r_cfg_tw);
        th_ext = THK_W'(r_cfg_th);
        if (tw_ext == '0) begin
            tw = TWC_W'(1);
        end else if (tw_ext > TWK_W'(MAX_TILE_WIDTH)) begin
            tw = TWC_W'(MAX_TILE_WIDTH);
        end else begin
            tw = TWC_W'(tw_ext);
        end
        if (th_ext == '0) begin
            th = THC_W'(1);
        end else if (th_ext > THK_W'(MAX_TILE_HEIGHT)) begin
            th = THC_W'(MAX_TILE_HEIGHT);
        end else begin
            th = THC_W'(th_ext);
        end
        if (r_cfg_iw == '0) begin
            iw = IMG_W'(1);
        end else if (r_cfg_iw > IMG_W'(tmlq_pkg::IMG_MAX)) begin
            iw = IMG_W'(tmlq_pkg::IMG_MAX);
        end else begin
            iw = r_cfg_iw;
        end
        if (r_cfg_ih == '0) begin
            ih = IMG_W'(1);
        end else if (r_cfg_ih > IMG_W'(tmlq_pkg::IMG_MAX)) begin
            ih = IMG_W'(tmlq_pkg::IMG_MAX);
        end else begin
            ih = r_cfg_ih;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;
    logic              r_s1_vld;
    t_s1               r_s1;
    t_s1               n_s1;
    logic [SUM_W-1:0]  r_rdata;
    logic [SUM_W-1:0]  r_fwd_data;

    logic [POS_W-1:0]  r_pcol, r_prow, r_tic, r_tir;
    logic [CIT_W-1:0]  r_cit;
    logic [RIT_W-1:0]  r_rit;
    logic [POS_W-1:0]  n_pcol, n_prow, n_tic, n_tir;
    logic [CIT_W-1:0]  n_cit;
    logic [RIT_W-1:0]  n_rit;

    tmlq_pkg::t_srch_stat srch_stat;
    logic              srch_start;
    logic              srch_take;

    logic              r_ovld;
    logic [tmlq_pkg::ROW_OUT_W-1:0] r_pend_row, r_o_row;
    logic [tmlq_pkg::COL_OUT_W-1:0] r_pend_col, r_o_col;
    logic              r_pend_last, r_o_last;
    logic [tmlq_pkg::LEVEL_W-1:0] r_o_level;

    logic              in_acc;

    // Hold the input during the clearing pass and while a tile is in flight
    assign i_pix.ready = !r_clr_busy && !srch_stat.busy && !(r_s1_vld && r_s1.emit);
    assign in_acc      = i_pix.valid && i_pix.ready;

    // ------------------------------------------------------------------
    // Position decode for the arriving pixel
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  e_pcol, e_prow, e_tic, e_tir;
    logic [CIT_W-1:0]  e_cit;
    logic [RIT_W-1:0]  e_rit;
    logic [PC_W-1:0]   prod_c;
    logic [PR_W-1:0]   prod_r;
    logic              col_ok, row_ok, col_last, row_last;
    logic              cit_end, rit_end;

    always_comb begin
        // frame start zeroes positions before the pixel is taken
        e_pcol = i_pix.frame_start ? '0 : r_pcol;
        e_prow = i_pix.frame_start ? '0 : r_prow;
        e_tic  = i_pix.frame_start ? '0 : r_tic;
        e_tir  = i_pix.frame_start ? '0 : r_tir;
        e_cit  = i_pix.frame_start ? '0 : r_cit;
        e_rit  = i_pix.frame_start ? '0 : r_rit;

        // the tile fits the image when (index + 1) * size <= image size
        prod_c = (PC_W'(e_tic) + PC_W'(1)) * PC_W'(tw);
        prod_r = (PR_W'(e_tir) + PR_W'(1)) * PR_W'(th);

        col_ok = (TIC_K'(e_tic) < TIC_K'(MAX_TILES_ACROSS))
              && (TWC_W'(e_cit) < tw) && (prod_c <= PC_W'(iw));
        row_ok = (THC_W'(e_rit) < th) && (prod_r <= PR_W'(ih));

        // last tile column: store limit reached or no room for another tile
        col_last = (TIC_K'(e_tic) == TIC_K'(MAX_TILES_ACROSS - 1))
                || (prod_c + PC_W'(tw) > PC_W'(iw));
        row_last = (prod_r + PR_W'(th) > PR_W'(ih));

        cit_end = (TWC_W'(e_cit) + TWC_W'(1) == tw);
        rit_end = (THC_W'(e_rit) + THC_W'(1) == th);
    end

    // Advance positions in raster order
    always_comb begin
        n_pcol = r_pcol;
        n_prow = r_prow;
        n_tic  = r_tic;
        n_tir  = r_tir;
        n_cit  = r_cit;
        n_rit  = r_rit;
        if (in_acc) begin
            n_prow = e_prow;
            n_tir  = e_tir;
            n_rit  = e_rit;
            if (IMG_W'(e_pcol) + IMG_W'(1) >= iw) begin
                n_pcol = '0;
                n_cit  = '0;
                n_tic  = '0;
                if (IMG_W'(e_prow) + IMG_W'(1) >= ih) begin
                    // frame end: wrap to a new frame
                    n_prow = '0;
                    n_tir  = '0;
                    n_rit  = '0;
                end else begin
                    n_prow = e_prow + POS_W'(1);
                    if (THC_W'(e_rit) + THC_W'(1) >= th) begin
                        n_rit = '0;
                        n_tir = e_tir + POS_W'(1);
                    end else begin
                        n_rit = e_rit + RIT_W'(1);
                    end
                end
            end else begin
                n_pcol = e_pcol + POS_W'(1);
                if (TWC_W'(e_cit) + TWC_W'(1) >= tw) begin
                    n_cit = '0;
                    n_tic = e_tic + POS_W'(1);
                end else begin
                    n_cit = e_cit + CIT_W'(1);
                    n_tic = e_tic;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcol <= '0;
            r_prow <= '0;
            r_tic  <= '0;
            r_tir  <= '0;
            r_cit  <= '0;
            r_rit  <= '0;
        end else begin
            r_pcol <= n_pcol;
            r_prow <= n_prow;
            r_tic  <= n_tic;
            r_tir  <= n_tir;
            r_cit  <= n_cit;
            r_rit  <= n_rit;
        end
    end

    // ------------------------------------------------------------------
    // Band sum store: read on accept, add and write back in the next cycle, no later
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] r_mem [MAX_TILES_ACROSS];
    logic [AW-1:0]    rd_addr;
    logic [SUM_W-1:0] sum_base;
    logic [SUM_W-1:0] sum_new;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SUM_W-1:0] mem_wdata;

    assign rd_addr = e_tic[AW-1:0];

    always_comb begin
        // forward the write of the previous pixel when it hits the same entry
        sum_base = r_s1.fwd ? r_fwd_data : r_rdata;
        // first pixel of a tile column in the band overwrites the stale sum
        sum_new  = r_s1.ovw ? SUM_W'(r_s1.pix) : sum_base + SUM_W'(r_s1.pix);

        mem_we    = r_clr_busy || (r_s1_vld && r_s1.wr);
        mem_waddr = r_clr_busy ? r_clr_addr : r_s1.addr;
        mem_wdata = r_clr_busy ? '0 : sum_new;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_s1.wr       = col_ok && row_ok;
        n_s1.ovw      = (e_cit == '0) && (e_rit == '0);
        n_s1.emit     = col_ok && row_ok && cit_end && rit_end;
        n_s1.last     = col_last && row_last;
        n_s1.fwd      = r_s1_vld && r_s1.wr && (r_s1.addr == rd_addr);
        n_s1.addr     = rd_addr;
        n_s1.pix      = i_pix.pixel;
        n_s1.tile_row = e_tir[tmlq_pkg::ROW_OUT_W-1:0];
        n_s1.tile_col = e_tic[tmlq_pkg::COL_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1       <= n_s1;
            r_fwd_data <= sum_new;
        end
    end

    // Clearing pass after reset, then the update stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_s1_vld <= in_acc;
        end
    end

    // ------------------------------------------------------------------
    // Level search and result register
    // ------------------------------------------------------------------
    logic [AREA_W-1:0] area;

    assign area       = AREA_W'(th) * AREA_W'(tw);
    assign srch_start = r_s1_vld && r_s1.emit;
    assign srch_take  = srch_stat.done && (!r_ovld || o_tile.ready);

    tmlq_level_search #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_sum   (sum_new),
        .i_area  (area),
        .i_take  (srch_take),
        .o_stat  (srch_stat)
    );

    // Hold the tile position while the level is searched
    always_ff @(posedge i_clk) begin
        if (srch_start) begin
            r_pend_row  <= r_s1.tile_row;
            r_pend_col  <= r_s1.tile_col;
            r_pend_last <= r_s1.last;
        end
        if (srch_take) begin
            r_o_row   <= r_pend_row;
            r_o_col   <= r_pend_col;
            r_o_last  <= r_pend_last;
            r_o_level <= srch_stat.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (srch_take) begin
            r_ovld <= 1'b1;
        end else if (o_tile.ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_tile.valid      = r_ovld;
    assign o_tile.tile_row   = r_o_row;
    assign o_tile.tile_col   = r_o_col;
    assign o_tile.level      = r_o_level;
    assign o_tile.frame_last = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a tile result only starts a search when the unit is free
    a_search_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_start |-> !srch_stat.busy)
        else $error("level search started while busy");

    // no pixel update overlaps the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_vld)
        else $error("store update during clearing pass");

    // a delivered level stays within the glyph range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tile.valid |-> (o_tile.level <= tmlq_pkg::LEVEL_MAX))
        else $error("level out of range");

    // a finished search is moved out the cycle after it is taken
    a_take_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_take |=> (r_ovld && !srch_stat.busy))
        else $error("search result not moved to output register");

endmodule
